### rtl/rmvs_pkg.sv
// Shared constants, types, state codes and command/status structs for the
// running mean / variance / standard error unit. No dependencies.
`default_nettype none

package rmvs_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 20;
   localparam int FRAC_BITS   = SAMPLE_BITS - 1;

   localparam int SUM_BITS  = COUNT_BITS + SAMPLE_BITS;
   localparam int SMAG_BITS = SUM_BITS - 1;
   localparam int SQ_BITS   = 2 * FRAC_BITS + 1;
   localparam int SSQ_BITS  = COUNT_BITS + 2 * FRAC_BITS;
   localparam int N2_BITS   = 2 * COUNT_BITS;
   localparam int N3_BITS   = 3 * COUNT_BITS;
   localparam int D_BITS    = 2 * COUNT_BITS + 2 * FRAC_BITS;
   localparam int VDEN_BITS = N2_BITS + FRAC_BITS;
   localparam int DEN_BITS  = (N3_BITS > VDEN_BITS) ? N3_BITS : VDEN_BITS;
   localparam int QUO_BITS  = (2 * FRAC_BITS > SAMPLE_BITS) ? 2 * FRAC_BITS : SAMPLE_BITS;
   localparam int DCNT_BITS = $clog2(QUO_BITS + 1);
   localparam int MULA_BITS = (SMAG_BITS > SQ_BITS) ? SMAG_BITS : SQ_BITS;
   localparam int MULB_BITS = (COUNT_BITS > SAMPLE_BITS) ? COUNT_BITS : SAMPLE_BITS;
   localparam int PROD_BITS = MULA_BITS + MULB_BITS;
   localparam int ROOT_BITS = FRAC_BITS;
   localparam int SREM_BITS = FRAC_BITS + 1;
   localparam int RAD_BITS  = 2 * FRAC_BITS;
   localparam int SCNT_BITS = $clog2(FRAC_BITS + 1);

   // quotient widths: each quotient is known to stay below 2^width
   localparam int QW_MEAN = SAMPLE_BITS;
   localparam int QW_VAR  = SAMPLE_BITS;
   localparam int QW_SE   = 2 * FRAC_BITS;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic        [SAMPLE_BITS-1:0] uq_type;
   typedef logic        [COUNT_BITS-1:0]  count_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;
   typedef logic        [SMAG_BITS-1:0]   smag_type;
   typedef logic        [SQ_BITS-1:0]     sq_type;
   typedef logic        [SSQ_BITS-1:0]    ssq_type;
   typedef logic        [N2_BITS-1:0]     n2_type;
   typedef logic        [N3_BITS-1:0]     n3_type;
   typedef logic        [D_BITS-1:0]      d_type;
   typedef logic        [DEN_BITS-1:0]    den_type;
   typedef logic        [QUO_BITS-1:0]    quo_type;
   typedef logic        [DCNT_BITS-1:0]   dcnt_type;
   typedef logic        [MULA_BITS-1:0]   mula_type;
   typedef logic        [MULB_BITS-1:0]   mulb_type;
   typedef logic        [PROD_BITS-1:0]   prod_type;
   typedef logic        [ROOT_BITS-1:0]   root_type;
   typedef logic        [SREM_BITS-1:0]   srem_type;
   typedef logic        [RAD_BITS-1:0]    rad_type;
   typedef logic        [SCNT_BITS-1:0]   scnt_type;

   localparam uq_type    ONE_Q     = {1'b1, {FRAC_BITS{1'b0}}};
   localparam count_type COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_SQ,
      ST_MUL_NSQ,
      ST_MUL_SX,
      ST_UPDATE,
      ST_MEAN_LD,
      ST_MEAN_RUN,
      ST_VAR_LD,
      ST_VAR_RUN,
      ST_SE_LD,
      ST_SE_RUN,
      ST_SQRT_RUN,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MUL_SQ,
      MUL_NSQ,
      MUL_SX
   } mul_sel_type;

   typedef enum logic [1:0] {
      DIV_MEAN,
      DIV_VAR,
      DIV_SE
   } div_sel_type;

   typedef struct packed {
      logic        accept;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        update;
      logic        div_load;
      logic        div_take;
      div_sel_type div_sel;
      logic        sqrt_load;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic sat;
      logic few;
      logic div_done;
      logic sqrt_done;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

### rtl/rmvs_if.sv
// Valid/ready channel interfaces for sample requests and statistics responses.
// Depends on rmvs_pkg for the payload types.
`default_nettype none

interface rmvs_req_if;
   logic                 valid;
   logic                 ready;
   rmvs_pkg::sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface rmvs_rsp_if;
   logic                valid;
   logic                ready;
   rmvs_pkg::uq_type    mean_value;
   rmvs_pkg::uq_type    variance_value;
   rmvs_pkg::uq_type    std_error;
   rmvs_pkg::count_type sample_count;
   logic                count_saturated;

   modport source (output valid, output mean_value, output variance_value,
                   output std_error, output sample_count, output count_saturated,
                   input ready);
   modport sink   (input valid, input mean_value, input variance_value,
                   input std_error, input sample_count, input count_saturated,
                   output ready);
endinterface

`default_nettype wire

### rtl/rmvs_div.sv
// Restoring divider, one quotient bit per cycle, shared by all three divisions.
// Depends on rmvs_pkg for widths.
`default_nettype none

module rmvs_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire rmvs_pkg::den_type  rem0,
   input  wire rmvs_pkg::d_type    num0,
   input  wire rmvs_pkg::den_type  den,
   input  wire rmvs_pkg::dcnt_type iters,
   output rmvs_pkg::quo_type       quo,
   output logic                    done
);

   rmvs_pkg::den_type  rem_ff, rem_in;
   rmvs_pkg::d_type    num_ff, num_in;
   rmvs_pkg::den_type  den_ff, den_in;
   rmvs_pkg::quo_type  quo_ff, quo_in;
   rmvs_pkg::dcnt_type cnt_ff, cnt_in;

   logic [rmvs_pkg::DEN_BITS:0] trial;
   logic [rmvs_pkg::DEN_BITS:0] diff;
   logic                        ge;

   always_comb begin
      trial  = {rem_ff, num_ff[rmvs_pkg::D_BITS-1]};
      diff   = trial - {1'b0, den_ff};
      ge     = trial >= {1'b0, den_ff};
      rem_in = rem_ff;
      num_in = num_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (load) begin
         rem_in = rem0;
         num_in = num0;
         den_in = den;
         quo_in = '0;
         cnt_in = iters;
      end else if (cnt_ff != '0) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = ge ? diff[rmvs_pkg::DEN_BITS-1:0] : trial[rmvs_pkg::DEN_BITS-1:0];
         num_in = num_ff << 1;
         quo_in = {quo_ff[rmvs_pkg::QUO_BITS-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quo  = quo_ff;
   assign done = (cnt_ff == '0);

endmodule

`default_nettype wire

### rtl/rmvs_datapath.sv
// Accumulators, shared multiplier, divider, square root and output register.
// Depends on rmvs_pkg, rmvs_if and rmvs_div.
`default_nettype none

module rmvs_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rmvs_pkg::sample_type sample,
   input  wire rmvs_pkg::cmd_type    cmd,
   output rmvs_pkg::stat_type        stat,
   rmvs_rsp_if.source                rsp_bus
);

   // running state
   rmvs_pkg::sum_type   sum_ff, sum_in;
   rmvs_pkg::ssq_type   ssq_ff, ssq_in;
   rmvs_pkg::count_type n_ff, n_in;
   rmvs_pkg::n2_type    n2_ff, n2_in;
   rmvs_pkg::n3_type    n3_ff, n3_in;
   rmvs_pkg::d_type     d_ff, d_in;

   // per-item working registers
   rmvs_pkg::sample_type x_ff, x_in;
   logic                 sat_ff, sat_in;
   rmvs_pkg::prod_type   prod_ff, prod_in;
   rmvs_pkg::sq_type     sq_ff, sq_in;
   rmvs_pkg::d_type      acc_ff, acc_in;
   rmvs_pkg::uq_type     mean_ff, mean_in;
   rmvs_pkg::uq_type     var_ff, var_in;
   rmvs_pkg::root_type   root_ff, root_in;
   rmvs_pkg::srem_type   srem_ff, srem_in;
   rmvs_pkg::rad_type    rad_ff, rad_in;
   rmvs_pkg::scnt_type   scnt_ff, scnt_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   rmvs_pkg::uq_type    out_mean_ff, out_mean_in;
   rmvs_pkg::uq_type    out_var_ff, out_var_in;
   rmvs_pkg::uq_type    out_se_ff, out_se_in;
   rmvs_pkg::count_type out_cnt_ff, out_cnt_in;
   logic                out_sat_ff, out_sat_in;

   rmvs_pkg::uq_type   xmag;
   rmvs_pkg::smag_type smag;
   rmvs_pkg::mula_type mul_a;
   rmvs_pkg::mulb_type mul_b;
   rmvs_pkg::d_type    twice_p;
   logic               sx_neg;
   logic               few;

   rmvs_pkg::d_type    div_num;
   rmvs_pkg::den_type  div_rem0;
   rmvs_pkg::d_type    div_num0;
   rmvs_pkg::den_type  div_den;
   rmvs_pkg::dcnt_type div_iters;
   rmvs_pkg::quo_type  div_quo;
   logic               div_done;

   logic [rmvs_pkg::SREM_BITS+1:0] srem_t;
   logic [rmvs_pkg::SREM_BITS+1:0] strial;
   logic                           sge;

   rmvs_div u_div (
      .clock (clock),
      .reset (reset),
      .load  (cmd.div_load),
      .rem0  (div_rem0),
      .num0  (div_num0),
      .den   (div_den),
      .iters (div_iters),
      .quo   (div_quo),
      .done  (div_done)
   );

   assign xmag = x_ff[rmvs_pkg::SAMPLE_BITS-1] ? rmvs_pkg::uq_type'(-x_ff)
                                               : rmvs_pkg::uq_type'(x_ff);
   assign smag = sum_ff[rmvs_pkg::SUM_BITS-1] ? rmvs_pkg::smag_type'(-sum_ff)
                                              : rmvs_pkg::smag_type'(sum_ff);
   assign sx_neg  = sum_ff[rmvs_pkg::SUM_BITS-1] ^ x_ff[rmvs_pkg::SAMPLE_BITS-1];
   assign twice_p = rmvs_pkg::d_type'(prod_ff) << 1;
   assign few     = (n_ff[rmvs_pkg::COUNT_BITS-1:1] == '0);

   // multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         rmvs_pkg::MUL_SQ: begin
            mul_a = rmvs_pkg::mula_type'(xmag);
            mul_b = rmvs_pkg::mulb_type'(xmag);
         end
         rmvs_pkg::MUL_NSQ: begin
            mul_a = rmvs_pkg::mula_type'(rmvs_pkg::sq_type'(prod_ff));
            mul_b = rmvs_pkg::mulb_type'(n_ff);
         end
         rmvs_pkg::MUL_SX: begin
            mul_a = rmvs_pkg::mula_type'(smag);
            mul_b = rmvs_pkg::mulb_type'(xmag);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // divider operand select; the initial remainder is the dividend's top part
   always_comb begin
      case (cmd.div_sel)
         rmvs_pkg::DIV_MEAN: begin
            div_num   = rmvs_pkg::d_type'(smag);
            div_den   = rmvs_pkg::den_type'(n_ff);
            div_rem0  = rmvs_pkg::den_type'(div_num >> rmvs_pkg::QW_MEAN);
            div_num0  = div_num << (rmvs_pkg::D_BITS - rmvs_pkg::QW_MEAN);
            div_iters = rmvs_pkg::dcnt_type'(rmvs_pkg::QW_MEAN);
         end
         rmvs_pkg::DIV_VAR: begin
            div_num   = d_ff;
            div_den   = rmvs_pkg::den_type'(n2_ff) << rmvs_pkg::FRAC_BITS;
            div_rem0  = rmvs_pkg::den_type'(div_num >> rmvs_pkg::QW_VAR);
            div_num0  = div_num << (rmvs_pkg::D_BITS - rmvs_pkg::QW_VAR);
            div_iters = rmvs_pkg::dcnt_type'(rmvs_pkg::QW_VAR);
         end
         rmvs_pkg::DIV_SE: begin
            div_num   = d_ff;
            div_den   = rmvs_pkg::den_type'(n3_ff);
            div_rem0  = rmvs_pkg::den_type'(div_num >> rmvs_pkg::QW_SE);
            div_num0  = div_num << (rmvs_pkg::D_BITS - rmvs_pkg::QW_SE);
            div_iters = rmvs_pkg::dcnt_type'(rmvs_pkg::QW_SE);
         end
         default: begin
            div_num   = '0;
            div_den   = '0;
            div_rem0  = '0;
            div_num0  = '0;
            div_iters = '0;
         end
      endcase
   end

   // square root step: two radicand bits per cycle
   always_comb begin
      srem_t = {srem_ff, rad_ff[rmvs_pkg::RAD_BITS-1 -: 2]};
      strial = {1'b0, root_ff, 2'b01};
      sge    = srem_t >= strial;
   end

   always_comb begin
      x_in    = x_ff;
      sat_in  = sat_ff;
      prod_in = prod_ff;
      sq_in   = sq_ff;
      acc_in  = acc_ff;
      sum_in  = sum_ff;
      ssq_in  = ssq_ff;
      n_in    = n_ff;
      n2_in   = n2_ff;
      n3_in   = n3_ff;
      d_in    = d_ff;
      mean_in = mean_ff;
      var_in  = var_ff;
      root_in = root_ff;
      srem_in = srem_ff;
      rad_in  = rad_ff;
      scnt_in = scnt_ff;

      if (cmd.accept) begin
         x_in   = sample;
         sat_in = (n_ff == rmvs_pkg::COUNT_MAX);
      end

      if (cmd.mul_en) begin
         prod_in = mul_a * mul_b;
         case (cmd.mul_sel)
            rmvs_pkg::MUL_SQ: begin
               // n^3 gains 3*n^2 here, 3*n + 1 in the next step
               n3_in = n3_ff + rmvs_pkg::n3_type'(n2_ff)
                       + (rmvs_pkg::n3_type'(n2_ff) << 1);
            end
            rmvs_pkg::MUL_NSQ: begin
               sq_in = rmvs_pkg::sq_type'(prod_ff);
               n3_in = n3_ff + rmvs_pkg::n3_type'(n_ff)
                       + (rmvs_pkg::n3_type'(n_ff) << 1) + 1'b1;
            end
            rmvs_pkg::MUL_SX: begin
               acc_in = d_ff + rmvs_pkg::d_type'(ssq_ff) + rmvs_pkg::d_type'(prod_ff);
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end

      if (cmd.update) begin
         // D' = D + Q + n*x^2 - 2*S*x, exact modulo the register width
         d_in   = sx_neg ? acc_ff + twice_p : acc_ff - twice_p;
         sum_in = sum_ff + rmvs_pkg::sum_type'(x_ff);
         ssq_in = ssq_ff + rmvs_pkg::ssq_type'(sq_ff);
         n_in   = n_ff + 1'b1;
         n2_in  = n2_ff + (rmvs_pkg::n2_type'(n_ff) << 1) + 1'b1;
      end

      if (cmd.div_take) begin
         case (cmd.div_sel)
            rmvs_pkg::DIV_MEAN: begin
               mean_in = sum_ff[rmvs_pkg::SUM_BITS-1]
                         ? (~rmvs_pkg::uq_type'(div_quo) + 1'b1)
                         : rmvs_pkg::uq_type'(div_quo);
            end
            rmvs_pkg::DIV_VAR: begin
               var_in = rmvs_pkg::uq_type'(div_quo);
            end
            default: begin
               var_in = var_ff;
            end
         endcase
      end

      if (cmd.sqrt_load) begin
         rad_in  = rmvs_pkg::rad_type'(div_quo);
         root_in = '0;
         srem_in = '0;
         scnt_in = rmvs_pkg::scnt_type'(rmvs_pkg::FRAC_BITS);
      end else if (scnt_ff != '0) begin
         srem_in = sge ? rmvs_pkg::srem_type'(srem_t - strial) : rmvs_pkg::srem_type'(srem_t);
         root_in = {root_ff[rmvs_pkg::ROOT_BITS-2:0], sge};
         rad_in  = rad_ff << 2;
         scnt_in = scnt_ff - 1'b1;
      end
   end

   // output register: hold until the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_mean_in  = out_mean_ff;
      out_var_in   = out_var_ff;
      out_se_in    = out_se_ff;
      out_cnt_in   = out_cnt_ff;
      out_sat_in   = out_sat_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         out_mean_in  = mean_ff;
         out_var_in   = few ? rmvs_pkg::ONE_Q : var_ff;
         out_se_in    = few ? rmvs_pkg::ONE_Q : rmvs_pkg::uq_type'(root_ff);
         out_cnt_in   = n_ff;
         out_sat_in   = sat_ff;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         ssq_ff       <= '0;
         n_ff         <= '0;
         n2_ff        <= '0;
         n3_ff        <= '0;
         d_ff         <= '0;
         scnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         ssq_ff       <= ssq_in;
         n_ff         <= n_in;
         n2_ff        <= n2_in;
         n3_ff        <= n3_in;
         d_ff         <= d_in;
         scnt_ff      <= scnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      sat_ff      <= sat_in;
      prod_ff     <= prod_in;
      sq_ff       <= sq_in;
      acc_ff      <= acc_in;
      mean_ff     <= mean_in;
      var_ff      <= var_in;
      root_ff     <= root_in;
      srem_ff     <= srem_in;
      rad_ff      <= rad_in;
      out_mean_ff <= out_mean_in;
      out_var_ff  <= out_var_in;
      out_se_ff   <= out_se_in;
      out_cnt_ff  <= out_cnt_in;
      out_sat_ff  <= out_sat_in;
   end

   assign stat.sat       = (n_ff == rmvs_pkg::COUNT_MAX);
   assign stat.few       = few;
   assign stat.div_done  = div_done;
   assign stat.sqrt_done = (scnt_ff == '0);
   assign stat.out_free  = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.mean_value      = out_mean_ff;
   assign rsp_bus.variance_value  = out_var_ff;
   assign rsp_bus.std_error       = out_se_ff;
   assign rsp_bus.sample_count    = out_cnt_ff;
   assign rsp_bus.count_saturated = out_sat_ff;

endmodule

`default_nettype wire

### rtl/rmvs_ctrl.sv
// Sequencing state machine: multiply, update, divide, square root, deliver.
// Depends on rmvs_pkg for state codes and command/status structs.
`default_nettype none

module rmvs_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire rmvs_pkg::stat_type stat,
   output rmvs_pkg::cmd_type       cmd
);

   rmvs_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rmvs_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.sat ? rmvs_pkg::ST_MEAN_LD : rmvs_pkg::ST_MUL_SQ;
            end
         end
         rmvs_pkg::ST_MUL_SQ:  state_in = rmvs_pkg::ST_MUL_NSQ;
         rmvs_pkg::ST_MUL_NSQ: state_in = rmvs_pkg::ST_MUL_SX;
         rmvs_pkg::ST_MUL_SX:  state_in = rmvs_pkg::ST_UPDATE;
         rmvs_pkg::ST_UPDATE:  state_in = rmvs_pkg::ST_MEAN_LD;
         rmvs_pkg::ST_MEAN_LD: state_in = rmvs_pkg::ST_MEAN_RUN;
         rmvs_pkg::ST_MEAN_RUN: begin
            if (stat.div_done) begin
               state_in = stat.few ? rmvs_pkg::ST_FINISH : rmvs_pkg::ST_VAR_LD;
            end
         end
         rmvs_pkg::ST_VAR_LD: state_in = rmvs_pkg::ST_VAR_RUN;
         rmvs_pkg::ST_VAR_RUN: begin
            if (stat.div_done) begin
               state_in = rmvs_pkg::ST_SE_LD;
            end
         end
         rmvs_pkg::ST_SE_LD: state_in = rmvs_pkg::ST_SE_RUN;
         rmvs_pkg::ST_SE_RUN: begin
            if (stat.div_done) begin
               state_in = rmvs_pkg::ST_SQRT_RUN;
            end
         end
         rmvs_pkg::ST_SQRT_RUN: begin
            if (stat.sqrt_done) begin
               state_in = rmvs_pkg::ST_FINISH;
            end
         end
         rmvs_pkg::ST_FINISH: begin
            if (stat.out_free) begin
               state_in = rmvs_pkg::ST_IDLE;
            end
         end
         default: state_in = rmvs_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      req_ready     = 1'b0;
      cmd.accept    = 1'b0;
      cmd.mul_en    = 1'b0;
      cmd.mul_sel   = rmvs_pkg::MUL_SQ;
      cmd.update    = 1'b0;
      cmd.div_load  = 1'b0;
      cmd.div_take  = 1'b0;
      cmd.div_sel   = rmvs_pkg::DIV_MEAN;
      cmd.sqrt_load = 1'b0;
      cmd.load_out  = 1'b0;
      case (state_ff)
         rmvs_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         rmvs_pkg::ST_MUL_SQ: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rmvs_pkg::MUL_SQ;
         end
         rmvs_pkg::ST_MUL_NSQ: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rmvs_pkg::MUL_NSQ;
         end
         rmvs_pkg::ST_MUL_SX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rmvs_pkg::MUL_SX;
         end
         rmvs_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         rmvs_pkg::ST_MEAN_LD: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = rmvs_pkg::DIV_MEAN;
         end
         rmvs_pkg::ST_MEAN_RUN: begin
            cmd.div_sel  = rmvs_pkg::DIV_MEAN;
            cmd.div_take = stat.div_done;
         end
         rmvs_pkg::ST_VAR_LD: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = rmvs_pkg::DIV_VAR;
         end
         rmvs_pkg::ST_VAR_RUN: begin
            cmd.div_sel  = rmvs_pkg::DIV_VAR;
            cmd.div_take = stat.div_done;
         end
         rmvs_pkg::ST_SE_LD: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = rmvs_pkg::DIV_SE;
         end
         rmvs_pkg::ST_SE_RUN: begin
            cmd.div_sel   = rmvs_pkg::DIV_SE;
            cmd.div_take  = stat.div_done;
            cmd.sqrt_load = stat.div_done;
         end
         rmvs_pkg::ST_FINISH: begin
            cmd.load_out = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmvs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/running_mean_variance_stderr_unit.sv
// Running mean, variance and standard error of signed Q1.15 samples.
// A new sample is taken only once the previous one has gone through the
// bit-serial divider (16+16+30 steps) and the 15-step square root, run one
// after another, and its result is parked in the response register.
// Reset (synchronous): sums, count and derived moments clear to zero.
`default_nettype none

module running_mean_variance_stderr_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   rmvs_req_if.sink   req_bus,
   rmvs_rsp_if.source rsp_bus
);

   // The datapath keeps S, Q and n, plus n^2, n^3 and D = n*Q - S^2 as
   // running terms, so each sample needs only three narrow products:
   // x^2, n*x^2 and |S|*|x|. D then advances as D + Q + n*x^2 - 2*S*x.
   //
   // Per sample the controller steps through:
   //   multiply x^2, multiply n*x^2, multiply |S|*|x|, update state,
   //   divide |S| / n          (mean, sign restored)
   //   divide D / (n^2 * 2^15) (variance)
   //   divide D / n^3          (argument for the standard error)
   //   square root of that argument, two bits per step
   // With fewer than two samples the variance and square root passes are
   // skipped and both read 1.0. A saturated count skips the multiply and
   // update steps and reports from the unchanged state.
   //
   // The response register parts the two sides: the next request transfer is
   // taken as soon as the last result is parked there, even while it waits.

   rmvs_pkg::cmd_type  cmd;
   rmvs_pkg::stat_type stat;

   rmvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rmvs_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .sample  (req_bus.sample),
      .cmd     (cmd),
      .stat    (stat),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire
